>>> hdl/grl_pkg.sv
// Package with the shared types, constants and the search step for the glyph range lookup.
`default_nettype none
package grl_pkg;

   localparam int MAX_RANGES  = 128;
   localparam int GLYPH_BYTES = 32;

   localparam int IDX_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W    = $clog2(MAX_RANGES + 1);
   localparam int PROBES   = $clog2(MAX_RANGES + 1);
   localparam int SLOT_W   = 7;
   localparam int CP_W     = 21;
   localparam int WORD_W   = 32;
   localparam int RC_W     = 8;
   localparam int OFF_W    = WORD_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] IDX_LIMIT = WORD_W'(64'hFFFF_FFFF / GLYPH_BYTES);

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [1:0] ST_HIT           = 2'd0;
   localparam logic [1:0] ST_NOT_LOADED    = 2'd1;
   localparam logic [1:0] ST_NO_RANGE      = 2'd2;
   localparam logic [1:0] ST_OUT_OF_BOUNDS = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LOADED = 2'd2;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] entry_index;
      logic [WORD_W-1:0] range_first;
      logic [WORD_W-1:0] range_last;
      logic [WORD_W-1:0] range_glyph_offset;
      logic [CP_W-1:0]   codepoint;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        lookup_status;
      logic [WORD_W-1:0] glyph_byte_offset;
   } rsp_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] last;
      logic [WORD_W-1:0] offset;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              is_write;
      logic              wr_ok;
      logic [IDX_W-1:0]  slot;
      entry_type         wr_entry;
      logic [CP_W-1:0]   codepoint;
      logic              loaded;
      logic [CNT_W-1:0]  lo;
      logic [CNT_W-1:0]  hi_end;
      logic              probe;
      logic [IDX_W-1:0]  mid;
      logic              found;
      logic [WORD_W-1:0] hit_first;
      logic [WORD_W-1:0] hit_offset;
   } pipe_type;

   // Folds the entry read at the previous probe into the search window.
   function automatic pipe_type merge_probe(pipe_type s, entry_type e);
      pipe_type          r;
      logic [WORD_W-1:0] cp;
      r  = s;
      cp = WORD_W'(s.codepoint);
      if (s.valid && s.probe) begin
         if (cp < e.first) begin
            r.hi_end = CNT_W'(s.mid);
         end else if (cp > e.last) begin
            r.lo = CNT_W'(s.mid) + CNT_W'(1);
         end else begin
            r.found      = 1'b1;
            r.hit_first  = e.first;
            r.hit_offset = e.offset;
         end
      end
      r.probe = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/grl_probe.sv
// One binary search step: resolves the previous probe and reads its own table copy.
`default_nettype none
module grl_probe (
   input  wire                      clock,
   input  wire                      reset,
   input  wire grl_pkg::pipe_type   up_stage,
   input  wire grl_pkg::entry_type  up_entry,
   output grl_pkg::pipe_type        down_stage,
   output grl_pkg::entry_type       down_entry
);
   import grl_pkg::*;

   entry_type         mem [MAX_RANGES];
   pipe_type          stage_in;
   pipe_type          stage_ff;
   entry_type         rd_ff;
   logic [CNT_W:0]    mid_sum;

   always_comb begin
      stage_in = merge_probe(up_stage, up_entry);
      mid_sum  = (CNT_W+1)'(stage_in.lo) + (CNT_W+1)'(stage_in.hi_end) - (CNT_W+1)'(1);
      stage_in.mid   = IDX_W'(mid_sum >> 1);
      stage_in.probe = stage_in.valid && !stage_in.is_write && stage_in.loaded &&
                       !stage_in.found && (stage_in.lo < stage_in.hi_end);
   end

   // Write items update this copy as they pass, so every item sees the table in order.
   always_ff @(posedge clock) begin
      if (up_stage.valid && up_stage.is_write && up_stage.wr_ok) begin
         mem[up_stage.slot] <= up_stage.wr_entry;
      end
      rd_ff <= mem[stage_in.mid];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign down_stage = stage_ff;
   assign down_entry = rd_ff;

endmodule
`default_nettype wire

>>> hdl/grl_resolve.sv
// Final probe merge, glyph offset arithmetic, bounds check and result register.
`default_nettype none
module grl_resolve (
   input  wire                       clock,
   input  wire                       reset,
   input  wire grl_pkg::pipe_type    up_stage,
   input  wire grl_pkg::entry_type   up_entry,
   input  wire [grl_pkg::WORD_W-1:0] data_size,
   output logic                      rsp_valid,
   output grl_pkg::rsp_item_type     rsp_item
);
   import grl_pkg::*;

   pipe_type          merged;
   logic [WORD_W-1:0] idx;

   logic              a_valid_in, a_valid_ff;
   logic              a_pending_in, a_pending_ff;
   logic [1:0]        a_status_in, a_status_ff;
   logic [WORD_W-1:0] a_idx_ff;
   logic [WORD_W-1:0] a_offset_ff;

   logic              b_valid_ff;
   logic              b_pending_ff;
   logic [1:0]        b_status_ff;
   logic [OFF_W-1:0]  b_sum_in, b_sum_ff;

   logic              c_valid_ff;
   rsp_item_type      c_item_in, c_item_ff;
   logic [OFF_W-1:0]  c_end;

   always_comb begin
      merged       = merge_probe(up_stage, up_entry);
      idx          = WORD_W'(merged.codepoint) - merged.hit_first;
      a_valid_in   = merged.valid && !merged.is_write;
      a_pending_in = 1'b0;
      if (!merged.loaded) begin
         a_status_in = ST_NOT_LOADED;
      end else if (!merged.found) begin
         a_status_in = ST_NO_RANGE;
      end else if (idx > IDX_LIMIT) begin
         a_status_in = ST_OUT_OF_BOUNDS;
      end else begin
         a_status_in  = ST_HIT;
         a_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_pending_ff <= a_pending_in;
      a_status_ff  <= a_status_in;
      a_idx_ff     <= idx;
      a_offset_ff  <= merged.hit_offset;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   assign b_sum_in = OFF_W'(a_offset_ff) + OFF_W'(OFF_W'(a_idx_ff) * OFF_W'(GLYPH_BYTES));

   always_ff @(posedge clock) begin
      b_pending_ff <= a_pending_ff;
      b_status_ff  <= a_status_ff;
      b_sum_ff     <= b_sum_in;
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   // The glyph must lie wholly inside the data image.
   always_comb begin
      c_end                       = b_sum_ff + OFF_W'(GLYPH_BYTES);
      c_item_in.lookup_status     = b_status_ff;
      c_item_in.glyph_byte_offset = '0;
      if (b_pending_ff) begin
         if (c_end > OFF_W'(data_size)) begin
            c_item_in.lookup_status = ST_OUT_OF_BOUNDS;
         end else begin
            c_item_in.lookup_status     = ST_HIT;
            c_item_in.glyph_byte_offset = b_sum_ff[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      c_item_ff <= c_item_in;
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   assign rsp_valid = c_valid_ff;
   assign rsp_item  = c_item_ff;

endmodule
`default_nettype wire

>>> hdl/glyph_range_lookup.sv
// Top level of the glyph range lookup: registers, entry stage and the search pipeline.
//
// Usage: the range table, the range count, the data size and the loaded flag
// are set up before lookups. Registers are written through the csr_ channel,
// whose ready is always high; index 0 is the entry count, 1 data_size and
// 2 table_loaded. Items enter on the req_ channel when start is high and busy
// is low; busy stays low, so an item can enter in every cycle.
// A write item stores one table entry and gives no result. A lookup item runs
// a binary search of eight probes, one per pipeline stage, each stage with its
// own copy of the table, which write items update as they pass that stage.
// Its result appears on rsp_item with rsp_valid high for one cycle, after the
// probe stages and the resolve registers, and is taken at the edge that ends that cycle.
// Throughput is one item per cycle, and results leave in the order the items
// entered. The receiver cannot stall the result channel; each result is shown once.
// Reset clears the registers and the pipeline valid bits. Table entries are
// not cleared and must be written before a lookup can reach them.
`default_nettype none
module glyph_range_lookup (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire grl_pkg::req_item_type          req_item,
   output logic                                rsp_valid,
   output grl_pkg::rsp_item_type               rsp_item,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [grl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [grl_pkg::WORD_W-1:0]           csr_wdata
);
   import grl_pkg::*;

   logic [RC_W-1:0]   entry_count_ff;
   logic [WORD_W-1:0] data_size_ff;
   logic              table_loaded_ff;

   pipe_type          entry_stage;
   entry_type         entry_none;
   logic [CNT_W-1:0]  count_clamped;

   pipe_type          stages  [PROBES+1];
   entry_type         entries [PROBES+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= '0;
         data_size_ff    <= '0;
         table_loaded_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENTRY_COUNT: begin
               entry_count_ff <= csr_wdata[RC_W-1:0];
            end
            CSR_DATA_SIZE: begin
               data_size_ff <= csr_wdata;
            end
            CSR_TABLE_LOADED: begin
               table_loaded_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign count_clamped = (32'(entry_count_ff) > MAX_RANGES) ? CNT_W'(MAX_RANGES)
                                                           : CNT_W'(entry_count_ff);

   always_comb begin
      entry_stage.valid              = start && !busy;
      entry_stage.is_write           = (req_item.action == ACT_WRITE);
      entry_stage.wr_ok              = (32'(req_item.entry_index) < MAX_RANGES);
      entry_stage.slot               = IDX_W'(req_item.entry_index);
      entry_stage.wr_entry.first     = req_item.range_first;
      entry_stage.wr_entry.last      = req_item.range_last;
      entry_stage.wr_entry.offset    = req_item.range_glyph_offset;
      entry_stage.codepoint          = req_item.codepoint;
      entry_stage.loaded             = table_loaded_ff;
      entry_stage.lo                 = '0;
      entry_stage.hi_end             = count_clamped;
      entry_stage.probe              = 1'b0;
      entry_stage.mid                = '0;
      entry_stage.found              = 1'b0;
      entry_stage.hit_first          = '0;
      entry_stage.hit_offset         = '0;
      entry_none                     = '0;
   end

   assign stages[0]  = entry_stage;
   assign entries[0] = entry_none;

   for (genvar g = 0; g < PROBES; g++) begin : g_probe
      grl_probe u_probe (
         .clock      (clock),
         .reset      (reset),
         .up_stage   (stages[g]),
         .up_entry   (entries[g]),
         .down_stage (stages[g+1]),
         .down_entry (entries[g+1])
      );
   end

   grl_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .up_stage  (stages[PROBES]),
      .up_entry  (entries[PROBES]),
      .data_size (data_size_ff),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

>>> dv/glyph_range_lookup_tb.sv
// Self-checking testbench for the glyph range lookup: directed and random tables, lookups and settings.
`default_nettype none
module glyph_range_lookup_tb;
   import grl_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [CP_W-1:0] CP_MAX = '1;

   class lookup_tracker;
      logic [WORD_W-1:0] first_tab [MAX_RANGES];
      logic [WORD_W-1:0] last_tab [MAX_RANGES];
      logic [WORD_W-1:0] off_tab [MAX_RANGES];
      logic [RC_W-1:0]   count;
      logic [WORD_W-1:0] size;
      logic              loaded;
      rsp_item_type      awaited [$];
      int                errors;

      function new();
         count  = '0;
         size   = '0;
         loaded = 1'b0;
         errors = 0;
         foreach (first_tab[i]) begin
            first_tab[i] = '0;
            last_tab[i]  = '0;
            off_tab[i]   = '0;
         end
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_ENTRY_COUNT: begin
               count = data[RC_W-1:0];
            end
            CSR_DATA_SIZE: begin
               size = data;
            end
            CSR_TABLE_LOADED: begin
               loaded = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      // Binary search in the fixed probe order; the first probed entry that holds the
      // codepoint decides the result, and the offset sum is checked without wrapping.
      function rsp_item_type find_glyph(logic [CP_W-1:0] cp);
         rsp_item_type      r;
         int                lo;
         int                hi;
         int                mid;
         logic [WORD_W-1:0] key;
         logic [WORD_W-1:0] idx;
         logic [63:0]       off;
         r.lookup_status     = ST_NO_RANGE;
         r.glyph_byte_offset = '0;
         key = WORD_W'(cp);
         if (!loaded) begin
            r.lookup_status = ST_NOT_LOADED;
            return r;
         end
         lo = 0;
         hi = ((int'(count) > MAX_RANGES) ? MAX_RANGES : int'(count)) - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < first_tab[mid]) begin
               hi = mid - 1;
            end else if (key > last_tab[mid]) begin
               lo = mid + 1;
            end else begin
               idx = key - first_tab[mid];
               off = {32'd0, off_tab[mid]} + {32'd0, idx} * 64'(GLYPH_BYTES);
               if (idx > IDX_LIMIT || off > {32'd0, size} ||
                   {32'd0, size} - off < 64'(GLYPH_BYTES)) begin
                  r.lookup_status = ST_OUT_OF_BOUNDS;
               end else begin
                  r.lookup_status     = ST_HIT;
                  r.glyph_byte_offset = off[WORD_W-1:0];
               end
               return r;
            end
         end
         return r;
      endfunction

      function void take_item(req_item_type it);
         if (it.action == ACT_WRITE) begin
            if (int'(it.entry_index) < MAX_RANGES) begin
               first_tab[it.entry_index] = it.range_first;
               last_tab[it.entry_index]  = it.range_last;
               off_tab[it.entry_index]   = it.range_glyph_offset;
            end
         end else begin
            awaited.push_back(find_glyph(it.codepoint));
         end
      endfunction

      function void check_lookup(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual status %0d offset %h",
                     $time, got.lookup_status, got.glyph_byte_offset);
            return;
         end
         want = awaited.pop_front();
         if (got.lookup_status !== want.lookup_status) begin
            errors++;
            $display("%0t: lookup_status mismatch: expected %0d, actual %0d",
                     $time, want.lookup_status, got.lookup_status);
         end
         if (got.glyph_byte_offset !== want.glyph_byte_offset) begin
            errors++;
            $display("%0t: glyph_byte_offset mismatch: expected %h, actual %h",
                     $time, want.glyph_byte_offset, got.glyph_byte_offset);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_item_type         req_item;
   logic                 rsp_valid;
   rsp_item_type         rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   lookup_tracker tracker;
   int            cycles;
   int            burst_left;
   int            sent;

   glyph_range_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_lookup(rsp_item);
      end
   end

   task automatic send_item(input req_item_type it);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.take_item(it);
      sent++;
   endtask

   task automatic issue_lookup(input logic [CP_W-1:0] cp);
      req_item_type it;
      it.action             = ACT_LOOKUP;
      it.entry_index        = SLOT_W'($urandom);
      it.range_first        = $urandom;
      it.range_last         = $urandom;
      it.range_glyph_offset = $urandom;
      it.codepoint          = cp;
      send_item(it);
   endtask

   task automatic store_entry(input int slot, input logic [WORD_W-1:0] lo_cp,
                              input logic [WORD_W-1:0] hi_cp, input logic [WORD_W-1:0] base);
      req_item_type it;
      it.action             = ACT_WRITE;
      it.entry_index        = SLOT_W'(slot);
      it.range_first        = lo_cp;
      it.range_last         = hi_cp;
      it.range_glyph_offset = base;
      it.codepoint          = CP_W'($urandom);
      send_item(it);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int n, input logic [WORD_W-1:0] bytes, input logic on);
      write_csr(CSR_ENTRY_COUNT, WORD_W'(n));
      write_csr(CSR_DATA_SIZE, bytes);
      write_csr(CSR_TABLE_LOADED, {31'd0, on});
   endtask

   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      return ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 32'h1F_FFFF);
   endfunction

   initial begin
      int                n;
      int                used;
      int                k;
      int                r;
      logic [WORD_W-1:0] cursor;
      logic [WORD_W-1:0] unit;
      logic [WORD_W-1:0] len;
      logic [WORD_W-1:0] oc;
      logic [WORD_W-1:0] bytes;
      tracker    = new();
      cycles     = 0;
      burst_left = 0;
      sent       = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_lookup('0);
      issue_lookup(CP_MAX);
      issue_lookup(CP_W'(32'h10_FFFF));
      settle();
      write_csr(CSR_TABLE_LOADED, 32'd1);
      issue_lookup(CP_W'(32'h41));

      // Ranges of 4096 codepoints every 8192, with an inverted entry, an entry whose
      // offset sum overflows 32 bits, and a last entry that reaches past Unicode.
      for (k = 0; k < MAX_RANGES; k++) begin
         store_entry(k, WORD_W'(k * 32'h2000), WORD_W'(k * 32'h2000 + 32'hFFF),
                     WORD_W'(k * 32'h2_0000));
      end
      store_entry(0, 32'd0, 32'hFFF, 32'd0);
      store_entry(125, 32'hF_A000, 32'hF_9FFF, 32'h0);
      store_entry(126, 32'hF_C000, 32'hF_CFFF, 32'hFFFF_FFF0);
      store_entry(127, 32'hF_E000, 32'hFFFF_FFFF, 32'h0);
      settle();
      configure(MAX_RANGES, 32'hFFFF_FFFF, 1'b1);
      issue_lookup(CP_W'(32'h0));
      issue_lookup(CP_W'(32'hFFF));
      issue_lookup(CP_W'(32'h1000));
      issue_lookup(CP_W'(32'hA007));
      issue_lookup(CP_W'(32'hF_A000));
      issue_lookup(CP_W'(32'hF_C000));
      issue_lookup(CP_W'(32'hF_C001));
      issue_lookup(CP_MAX);
      settle();
      configure(MAX_RANGES, 32'h2_0000, 1'b1);
      issue_lookup(CP_W'(32'hFFF));
      issue_lookup(CP_W'(32'h2000));
      settle();
      configure(255, 32'h0, 1'b1);
      issue_lookup(CP_W'(32'h0));
      settle();
      configure(255, 32'hFFFF_FFFF, 1'b1);
      issue_lookup(CP_MAX);
      settle();
      configure(1, 32'hFFFF_FFFF, 1'b1);
      issue_lookup(CP_W'(32'h10));
      issue_lookup(CP_W'(32'h2000));

      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 7))
            0: begin
               n = 0;
            end
            1: begin
               n = 1;
            end
            2: begin
               n = MAX_RANGES;
            end
            3: begin
               n = 255;
            end
            4: begin
               n = MAX_RANGES - 1;
            end
            default: begin
               n = $urandom_range(2, 255);
            end
         endcase
         used = (n > MAX_RANGES) ? MAX_RANGES : n;

         if ($urandom_range(0, 4) == 0) begin
            oc = $urandom;
            for (k = 0; k < used; k++) begin
               store_entry(k, rand_word(), rand_word(), $urandom);
               pace();
            end
         end else begin
            cursor = $urandom_range(0, 255);
            oc     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
            unit   = $urandom_range(1, 32'h20_0000 / (used + 1));
            for (k = 0; k < used; k++) begin
               cursor = cursor + $urandom_range(0, unit);
               len    = $urandom_range(1, unit);
               if ($urandom_range(0, 19) == 0) begin
                  store_entry(k, cursor, cursor - 1, oc);
               end else begin
                  store_entry(k, cursor, cursor + len - 1, oc);
               end
               oc = oc + len * 32'(GLYPH_BYTES) +
                    (($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : 32'd0);
               cursor = cursor + len;
               pace();
            end
         end
         settle();

         case ($urandom_range(0, 6))
            0: begin
               bytes = oc - $urandom_range(1, 64);
            end
            1: begin
               bytes = '0;
            end
            2: begin
               bytes = '1;
            end
            3: begin
               bytes = $urandom;
            end
            default: begin
               bytes = oc;
            end
         endcase
         configure(n, bytes, $urandom_range(0, 9) != 0);

         repeat ($urandom_range(60, 200)) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               store_entry($urandom_range(0, MAX_RANGES - 1), rand_word(), rand_word(), $urandom);
            end else if (r < 18 || used == 0) begin
               issue_lookup(CP_W'($urandom));
            end else begin
               k = $urandom_range(0, used - 1);
               case ($urandom_range(0, 5))
                  0: begin
                     issue_lookup(CP_W'(tracker.first_tab[k]));
                  end
                  1: begin
                     issue_lookup(CP_W'(tracker.last_tab[k]));
                  end
                  2: begin
                     issue_lookup(CP_W'(tracker.last_tab[k] + 1));
                  end
                  3: begin
                     issue_lookup(CP_W'(tracker.first_tab[k] - 1));
                  end
                  default: begin
                     issue_lookup(CP_W'(tracker.first_tab[k] +
                        $urandom_range(0, tracker.last_tab[k] - tracker.first_tab[k])));
                  end
               endcase
            end
            pace();
            if ($urandom_range(0, 299) == 0) begin
               settle();
            end
         end
      end

      settle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
hdl/grl_pkg.sv
hdl/grl_probe.sv
hdl/grl_resolve.sv
hdl/glyph_range_lookup.sv
dv/glyph_range_lookup_tb.sv
